/* rtl/rsbkd_pkg.sv */
// Shared defaults for the descending record sorter.
`timescale 1ns / 1ps

package rsbkd_pkg;

  localparam int unsigned MaxRecordsDef = 64;
  localparam int unsigned KeyBitsDef    = 8;
  localparam int unsigned TagBitsDef    = 16;

endpackage

/* rtl/rsbkd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsbkd_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/record_sort_by_key_descending.sv */
// Top level: collects a record set, exchange-sorts it by key in RAM, emits it descending.
//
//   channel | direction | payload                              | handshake
//   --------+-----------+--------------------------------------+-------------------------
//   in      | into      | item_key_i, item_tag_i, last_in_i    | in_valid_i / in_stall_o
//   out     | out of    | out_key_o, out_tag_o, out_last_o,    | out_valid_o / out_stall_i
//           |           | dropped_o                            |
//
// Load: accepts one input beat per cycle; records past MAX_RECORDS are discarded and flagged.
// Sort: each pass reads its head record, scans the later records through the single RAM
//   read port and writes the largest back to the head slot.
// Output: each result beat is read from RAM, then captured in the output register, and held there under stall.
// Input is stalled from the closing beat until the last result beat is taken.
// Reset clears control and output registers; the record RAM needs no clearing since only filled
//   entries are read.
`timescale 1ns / 1ps

module record_sort_by_key_descending #(
  parameter int unsigned MAX_RECORDS = rsbkd_pkg::MaxRecordsDef,
  parameter int unsigned KEY_BITS    = rsbkd_pkg::KeyBitsDef,
  parameter int unsigned TAG_BITS    = rsbkd_pkg::TagBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KEY_BITS-1:0] item_key_i,
  input  logic [TAG_BITS-1:0] item_tag_i,
  input  logic                last_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [KEY_BITS-1:0] out_key_o,
  output logic [TAG_BITS-1:0] out_tag_o,
  output logic                out_last_o,
  output logic                dropped_o
);

  import rsbkd_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int unsigned REC_W = KEY_BITS + TAG_BITS;
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_RECORDS);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_HEAD,
    S_SCAN,
    S_WB,
    S_OUT_RD,
    S_OUT_CAP,
    S_OUT_HOLD
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    fill_q;
  logic                ovf_q;
  logic [AW-1:0]       a_q;
  logic [AW-1:0]       rb_q;
  logic [KEY_BITS-1:0] held_key_q;
  logic [TAG_BITS-1:0] held_tag_q;
  logic                out_valid_q;
  logic [KEY_BITS-1:0] out_key_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic                out_last_q;
  logic                dropped_q;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [REC_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [REC_W-1:0]    ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0] rd_tag;

  logic                in_acc;
  logic                full;
  logic [CNT_W-1:0]    last_idx;
  logic                pass_done;
  logic                swap;
  logic                scan_end;
  logic                out_acc;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_q && !out_stall_i;
  assign full      = (fill_q == CntMax);
  assign last_idx  = fill_q - CNT_W'(1);
  assign pass_done = (CNT_W'(a_q) >= last_idx);
  assign rd_key    = ram_rdata[REC_W-1 -: KEY_BITS];
  assign rd_tag    = ram_rdata[TAG_BITS-1:0];
  assign swap      = (held_key_q < rd_key);
  assign scan_end  = (CNT_W'(rb_q) == last_idx);

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_tag_o   = out_tag_q;
  assign out_last_o  = out_last_q;
  assign dropped_o   = dropped_q;

  // Steer the RAM ports for load, sort passes and readout
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_q;
    ram_wdata = {held_key_q, held_tag_q};
    ram_re    = 1'b0;
    ram_raddr = a_q;
    case (state_q)
      S_LOAD: begin
        ram_we    = in_acc && !full;
        ram_waddr = fill_q[AW-1:0];
        ram_wdata = {item_key_i, item_tag_i};
      end
      S_PASS: begin
        ram_re = !pass_done;
      end
      S_HEAD: begin
        ram_re    = 1'b1;
        ram_raddr = a_q + AW'(1);
      end
      S_SCAN: begin
        ram_we    = swap;
        ram_waddr = rb_q;
        ram_re    = !scan_end;
        ram_raddr = rb_q + AW'(1);
      end
      S_WB: begin
        ram_we = 1'b1;
      end
      S_OUT_RD: begin
        ram_re = 1'b1;
      end
      S_OUT_HOLD: begin
        ram_re    = out_acc && !out_last_q;
        ram_raddr = a_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  rsbkd_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequence load, sort passes and readout; hold registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      a_q         <= '0;
      rb_q        <= '0;
      held_key_q  <= '0;
      held_tag_q  <= '0;
      out_valid_q <= 1'b0;
      out_key_q   <= '0;
      out_tag_q   <= '0;
      out_last_q  <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              fill_q <= fill_q + CNT_W'(1);
            end
            if (last_in_i) begin
              a_q     <= '0;
              state_q <= S_PASS;
            end
          end
        end
        S_PASS: begin
          if (pass_done) begin
            a_q     <= '0;
            state_q <= S_OUT_RD;
          end else begin
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          // Head record of the pass stays in registers
          held_key_q <= rd_key;
          held_tag_q <= rd_tag;
          rb_q       <= a_q + AW'(1);
          state_q    <= S_SCAN;
        end
        S_SCAN: begin
          // Keep the larger key at the head, drop the smaller back to the scanned slot
          if (swap) begin
            held_key_q <= rd_key;
            held_tag_q <= rd_tag;
          end
          if (scan_end) begin
            state_q <= S_WB;
          end else begin
            rb_q <= rb_q + AW'(1);
          end
        end
        S_WB: begin
          a_q     <= a_q + AW'(1);
          state_q <= S_PASS;
        end
        S_OUT_RD: begin
          state_q <= S_OUT_CAP;
        end
        S_OUT_CAP: begin
          out_valid_q <= 1'b1;
          out_key_q   <= rd_key;
          out_tag_q   <= rd_tag;
          out_last_q  <= (CNT_W'(a_q) == last_idx);
          dropped_q   <= ovf_q;
          state_q     <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              fill_q  <= '0;
              ovf_q   <= 1'b0;
              a_q     <= '0;
              state_q <= S_LOAD;
            end else begin
              a_q     <= a_q + AW'(1);
              state_q <= S_OUT_CAP;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  // Fill count never passes capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntMax)
    else $error("fill count beyond capacity");

  // A result beat always comes from a non-empty set
  a_out_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fill_q != '0))
    else $error("result beat with empty set");

  // A swap during a scan strictly raises the held key
  a_swap_raises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && swap) |=> (held_key_q > $past(held_key_q)))
    else $error("swap did not raise held key");

  // Taking the final beat reopens loading with an empty set
  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_q) |=> (state_q == S_LOAD && fill_q == '0 && !ovf_q))
    else $error("set not closed after final beat");

endmodule
